@@ src/lbcd_pkg.sv @@
`timescale 1ns / 1ps
package lbcd_pkg;
    localparam int BUFFER_COUNT = 32;
    localparam int IDX_W = 5;
    localparam int CNT_MAX = 255;

    localparam logic [2:0] OP_GET = 3'd0;
    localparam logic [2:0] OP_MARK_VALID = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_PIN = 3'd3;
    localparam logic [2:0] OP_UNPIN = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_WRITE,
        S_SHIFT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [4:0]  buffer_index;
    } req_t;

    typedef struct packed {
        logic [4:0] entry;
        logic       hit;
        logic       contents_valid;
        logic [7:0] references;
        logic [1:0] status;
    } rsp_t;
endpackage

@@ src/lbcd_if.sv @@
`timescale 1ns / 1ps
interface lbcd_req_if;
    logic             valid;
    logic             ready;
    lbcd_pkg::req_t   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lbcd_rsp_if;
    logic             valid;
    logic             ready;
    lbcd_pkg::rsp_t   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/lru_buffer_cache_directory_top.sv @@
`timescale 1ns / 1ps
// A get reads the recency order one rank at a time, first looking
// for a matching tag and then, on a miss, for a free entry from the least recent
// end; a release that frees an entry then moves it to most recent.
// One word is in flight at a time; the result register holds until taken, and
// the next word can be accepted in the cycle after that.
// Reset (rst_n, asynchronous, low) clears control state and the small per-entry
// stores, tag entries read as zero until first written, and the recency order
// returns to entry BUFFER_COUNT-1 as most recent.
module lru_buffer_cache_directory_top (
    input logic clk,
    input logic rst_n,
    lbcd_req_if.sink   in_if,
    lbcd_rsp_if.source out_if
);
    localparam int N = lbcd_pkg::BUFFER_COUNT;
    localparam int IW = lbcd_pkg::IDX_W;

    // Tag memory: synchronous read, one write port and one read port.
    logic [39:0] tag_mem [N];
    logic [39:0] tag_rd_reg;
    logic [N-1:0] tag_set_reg;
    // Per-entry count/valid and recency order live in flip-flops (reset values).
    logic [7:0]    cnt_reg [N];
    logic [N-1:0]  vld_reg;
    logic [IW-1:0] ord_reg [N];

    lbcd_pkg::state_t state_reg, state_next;
    lbcd_pkg::req_t   req_reg;
    lbcd_pkg::rsp_t   rsp_reg, rsp_next;
    logic [IW:0]      rank_reg, rank_next;
    logic             phase_reg, phase_next;   // 0: hit search, 1: victim search
    logic [IW-1:0]    cur_reg;
    logic             rsp_valid_reg;
    logic [IW-1:0]    tgt_reg, tgt_next;

    logic [IW-1:0] scan_e;
    logic          tag_we;
    logic          idx_ok;
    logic [39:0]   tag_q;

    assign scan_e = ord_reg[rank_reg[IW-1:0]];
    // An entry whose tag was never written holds the all-zero reset tag.
    assign tag_q = tag_set_reg[cur_reg] ? tag_rd_reg : 40'd0;
    assign idx_ok = ({1'b0, req_reg.buffer_index} < (IW+1)'(N));
    assign in_if.ready = (state_reg == lbcd_pkg::S_IDLE) && !rsp_valid_reg;
    assign out_if.valid = rsp_valid_reg;
    assign out_if.data = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tgt_reg] <= {req_reg.device, req_reg.block_number};
        end
        tag_rd_reg <= tag_mem[scan_e];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lbcd_pkg::S_IDLE:
                if (in_if.valid && in_if.ready)
                begin
                    state_next = (in_if.data.cmd == lbcd_pkg::OP_GET) ?
                                 lbcd_pkg::S_SCAN : lbcd_pkg::S_READ;
                end
            lbcd_pkg::S_SCAN:
                state_next = lbcd_pkg::S_READ;
            lbcd_pkg::S_READ:
                if (req_reg.cmd != lbcd_pkg::OP_GET)
                    state_next = lbcd_pkg::S_WRITE;
                else if (!phase_reg &&
                         tag_q == {req_reg.device, req_reg.block_number})
                    state_next = lbcd_pkg::S_WRITE;
                else if (phase_reg && cnt_reg[cur_reg] == 8'd0)
                    state_next = lbcd_pkg::S_WRITE;
                else if (!phase_reg && rank_reg == (IW+1)'(N - 1))
                    state_next = lbcd_pkg::S_SCAN;
                else if (phase_reg && rank_reg == '0)
                    state_next = lbcd_pkg::S_OUT;
                else
                    state_next = lbcd_pkg::S_SCAN;
            lbcd_pkg::S_WRITE:
                state_next = (rsp_reg.status == lbcd_pkg::ST_OK &&
                              req_reg.cmd == lbcd_pkg::OP_RELEASE && idx_ok &&
                              rsp_reg.references == 8'd0) ?
                             lbcd_pkg::S_SHIFT : lbcd_pkg::S_OUT;
            lbcd_pkg::S_SHIFT:
                if (rank_reg == '0 || ord_reg[rank_reg[IW-1:0]] == tgt_reg)
                    state_next = lbcd_pkg::S_OUT;
            lbcd_pkg::S_OUT:
                state_next = lbcd_pkg::S_IDLE;
            default:
                state_next = lbcd_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_next = rsp_reg;
        rank_next = rank_reg;
        phase_next = phase_reg;
        tgt_next = tgt_reg;
        tag_we = 1'b0;
        case (state_reg)
            lbcd_pkg::S_IDLE:
            begin
                rank_next = '0;
                phase_next = 1'b0;
                tgt_next = in_if.data.buffer_index;
            end
            lbcd_pkg::S_READ:
            begin
                if (req_reg.cmd != lbcd_pkg::OP_GET)
                begin
                    rsp_next = '0;
                    rsp_next.entry = req_reg.buffer_index;
                    if (idx_ok)
                    begin
                        rsp_next.contents_valid = vld_reg[tgt_reg];
                        rsp_next.references = cnt_reg[tgt_reg];
                        case (req_reg.cmd)
                            lbcd_pkg::OP_MARK_VALID:
                                rsp_next.contents_valid = 1'b1;
                            lbcd_pkg::OP_RELEASE, lbcd_pkg::OP_UNPIN:
                                if (cnt_reg[tgt_reg] == 8'd0)
                                    rsp_next.status = lbcd_pkg::ST_UNDERFLOW;
                                else
                                    rsp_next.references = cnt_reg[tgt_reg] - 8'd1;
                            lbcd_pkg::OP_PIN:
                                if (cnt_reg[tgt_reg] == 8'(lbcd_pkg::CNT_MAX))
                                    rsp_next.status = lbcd_pkg::ST_OVERFLOW;
                                else
                                    rsp_next.references = cnt_reg[tgt_reg] + 8'd1;
                            default:
                                ;
                        endcase
                    end
                end
                else if (!phase_reg &&
                         tag_q == {req_reg.device, req_reg.block_number})
                begin
                    tgt_next = cur_reg;
                    rsp_next.entry = cur_reg;
                    rsp_next.hit = 1'b1;
                    rsp_next.contents_valid = vld_reg[cur_reg];
                    if (cnt_reg[cur_reg] == 8'(lbcd_pkg::CNT_MAX))
                    begin
                        rsp_next.references = cnt_reg[cur_reg];
                        rsp_next.status = lbcd_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        rsp_next.references = cnt_reg[cur_reg] + 8'd1;
                        rsp_next.status = lbcd_pkg::ST_OK;
                    end
                end
                else if (phase_reg && cnt_reg[cur_reg] == 8'd0)
                begin
                    tgt_next = cur_reg;
                    rsp_next = '0;
                    rsp_next.entry = cur_reg;
                    rsp_next.references = 8'd1;
                end
                else if (!phase_reg && rank_reg == (IW+1)'(N - 1))
                begin
                    phase_next = 1'b1;
                end
                else if (phase_reg && rank_reg == '0)
                begin
                    rsp_next = '0;
                    rsp_next.status = lbcd_pkg::ST_NO_FREE;
                end
                else if (phase_reg)
                    rank_next = rank_reg - 1'b1;
                else
                    rank_next = rank_reg + 1'b1;
            end
            lbcd_pkg::S_WRITE:
            begin
                tag_we = (req_reg.cmd == lbcd_pkg::OP_GET) && !rsp_reg.hit;
                // Locate the freed entry from the least recent end.
                rank_next = (IW+1)'(N - 1);
            end
            lbcd_pkg::S_SHIFT:
                if (rank_reg != '0 && ord_reg[rank_reg[IW-1:0]] != tgt_reg)
                    rank_next = rank_reg - 1'b1;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbcd_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            vld_reg <= '0;
            tag_set_reg <= '0;
            rank_reg <= '0;
            phase_reg <= 1'b0;
            for (int k = 0; k < N; k++)
            begin
                cnt_reg[k] <= 8'd0;
                ord_reg[k] <= IW'(N - 1 - k);
            end
        end
        else
        begin
            state_reg <= state_next;
            rank_reg <= rank_next;
            phase_reg <= phase_next;
            if (tag_we)
                tag_set_reg[tgt_reg] <= 1'b1;
            if (out_if.valid && out_if.ready)
                rsp_valid_reg <= 1'b0;
            else if (state_reg == lbcd_pkg::S_OUT)
                rsp_valid_reg <= 1'b1;
            if (state_reg == lbcd_pkg::S_WRITE &&
                (req_reg.cmd == lbcd_pkg::OP_GET || idx_ok))
            begin
                cnt_reg[tgt_reg] <= rsp_reg.references;
                vld_reg[tgt_reg] <= rsp_reg.contents_valid;
            end
            // Found rank r of the entry: ranks 0..r-1 move down one.
            if (state_reg == lbcd_pkg::S_SHIFT &&
                ord_reg[rank_reg[IW-1:0]] == tgt_reg)
            begin
                for (int k = 1; k < N; k++)
                    if (k[IW:0] <= rank_reg)
                        ord_reg[k] <= ord_reg[k-1];
                ord_reg[0] <= tgt_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_if.valid && in_if.ready)
            req_reg <= in_if.data;
        rsp_reg <= rsp_next;
        tgt_reg <= tgt_next;
        cur_reg <= scan_e;
    end

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> state_reg == lbcd_pkg::S_IDLE)
        else $error("result pending while busy");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lbcd_pkg::S_IDLE) |-> !in_if.ready)
        else $error("accept while busy");
    a_hit_get: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.hit) |-> req_reg.cmd == lbcd_pkg::OP_GET)
        else $error("hit on non-get");
endmodule

@@ test/lbcd_checker.sv @@
`timescale 1ns / 1ps
module lbcd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input lbcd_pkg::req_t req_data,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input lbcd_pkg::rsp_t rsp_data,
    output int            failures,
    output int            pending
);
    logic [7:0]                 dev_tag [lbcd_pkg::BUFFER_COUNT];
    logic [31:0]                blk_tag [lbcd_pkg::BUFFER_COUNT];
    logic                       filled [lbcd_pkg::BUFFER_COUNT];
    logic [7:0]                 refcnt [lbcd_pkg::BUFFER_COUNT];
    logic [lbcd_pkg::IDX_W-1:0] order [lbcd_pkg::BUFFER_COUNT];
    lbcd_pkg::rsp_t             expected_rsp [$];

    function automatic void reset_directory();
        for (int k = 0; k < lbcd_pkg::BUFFER_COUNT; k++)
        begin
            dev_tag[k] = '0;
            blk_tag[k] = '0;
            filled[k] = 1'b0;
            refcnt[k] = '0;
            order[k] = lbcd_pkg::IDX_W'(lbcd_pkg::BUFFER_COUNT - 1 - k);
        end
    endfunction

    function automatic void promote(int e);
        int r;
        r = 0;
        while (r < lbcd_pkg::BUFFER_COUNT && order[r] != e)
            r++;
        while (r > 0)
        begin
            order[r] = order[r - 1];
            r--;
        end
        order[0] = lbcd_pkg::IDX_W'(e);
    endfunction

    function automatic lbcd_pkg::rsp_t lookup_outcome(lbcd_pkg::req_t q);
        lbcd_pkg::rsp_t o;
        int e;
        int idx;
        o = '0;
        if (q.cmd == lbcd_pkg::OP_GET)
        begin
            for (int r = 0; r < lbcd_pkg::BUFFER_COUNT; r++)
            begin
                e = order[r];
                if (dev_tag[e] == q.device && blk_tag[e] == q.block_number)
                begin
                    if (refcnt[e] == lbcd_pkg::CNT_MAX)
                        o.status = lbcd_pkg::ST_OVERFLOW;
                    else
                        refcnt[e]++;
                    o.entry = lbcd_pkg::IDX_W'(e);
                    o.hit = 1'b1;
                    o.contents_valid = filled[e];
                    o.references = refcnt[e];
                    return o;
                end
            end
            for (int r = lbcd_pkg::BUFFER_COUNT - 1; r >= 0; r--)
            begin
                e = order[r];
                if (refcnt[e] == 0)
                begin
                    dev_tag[e] = q.device;
                    blk_tag[e] = q.block_number;
                    filled[e] = 1'b0;
                    refcnt[e] = 8'd1;
                    o.entry = lbcd_pkg::IDX_W'(e);
                    o.references = 8'd1;
                    return o;
                end
            end
            o.status = lbcd_pkg::ST_NO_FREE;
            return o;
        end
        idx = q.buffer_index;
        o.entry = q.buffer_index;
        if (idx >= lbcd_pkg::BUFFER_COUNT)
            return o;
        case (q.cmd)
            lbcd_pkg::OP_MARK_VALID: filled[idx] = 1'b1;
            lbcd_pkg::OP_RELEASE:
            begin
                if (refcnt[idx] == 0)
                    o.status = lbcd_pkg::ST_UNDERFLOW;
                else
                begin
                    refcnt[idx]--;
                    if (refcnt[idx] == 0)
                        promote(idx);
                end
            end
            lbcd_pkg::OP_PIN:
            begin
                if (refcnt[idx] == lbcd_pkg::CNT_MAX)
                    o.status = lbcd_pkg::ST_OVERFLOW;
                else
                    refcnt[idx]++;
            end
            lbcd_pkg::OP_UNPIN:
            begin
                if (refcnt[idx] == 0)
                    o.status = lbcd_pkg::ST_UNDERFLOW;
                else
                    refcnt[idx]--;
            end
            default: ;
        endcase
        o.contents_valid = filled[idx];
        o.references = refcnt[idx];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lbcd_pkg::rsp_t want;
        if (!rst_n)
        begin
            reset_directory();
            expected_rsp.delete();
            failures <= 0;
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("unexpected result word %p", rsp_data);
                    failures <= failures + 1;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (want != rsp_data)
                    begin
                        if (want.entry != rsp_data.entry)
                            $error("entry: expected %0d, got %0d", want.entry, rsp_data.entry);
                        if (want.hit != rsp_data.hit)
                            $error("hit: expected %0d, got %0d", want.hit, rsp_data.hit);
                        if (want.contents_valid != rsp_data.contents_valid)
                            $error("contents_valid: expected %0d, got %0d",
                                   want.contents_valid, rsp_data.contents_valid);
                        if (want.references != rsp_data.references)
                            $error("references: expected %0d, got %0d",
                                   want.references, rsp_data.references);
                        if (want.status != rsp_data.status)
                            $error("status: expected %0d, got %0d",
                                   want.status, rsp_data.status);
                        failures <= failures + 1;
                    end
                end
            end
            if (req_valid && req_ready)
                expected_rsp.push_back(lookup_outcome(req_data));
            pending <= expected_rsp.size();
        end
    end
endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    bit   receiver_hold;
    longint cycles;

    lbcd_req_if in_if ();
    lbcd_rsp_if out_if ();

    lru_buffer_cache_directory_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_if  (in_if),
        .out_if (out_if)
    );

    lbcd_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_if.valid),
        .req_ready (in_if.ready),
        .req_data  (in_if.data),
        .rsp_valid (out_if.valid),
        .rsp_ready (out_if.ready),
        .rsp_data  (out_if.data),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        sender_idle_pct = 21;
        receiver_idle_pct = 77;
        receiver_hold = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_if.ready <= !receiver_hold && ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // A small working set of tags keeps gets hitting and entries busy.
    function automatic lbcd_pkg::req_t make_word();
        lbcd_pkg::req_t q;
        int pick;
        q.cmd = 3'($urandom_range(4));
        pick = $urandom_range(99);
        if (pick < 5)
            q.cmd = 3'($urandom_range(7, 5));
        q.device = 8'($urandom_range(3));
        q.block_number = 32'($urandom_range(40));
        if ($urandom_range(9) == 0)
        begin
            q.device = 8'($urandom);
            q.block_number = $urandom;
        end
        q.buffer_index = 5'($urandom);
        return q;
    endfunction

    task automatic send(lbcd_pkg::req_t q);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= q;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
    endtask

    task automatic send_cmd(logic [2:0] c, logic [7:0] d, logic [31:0] b, logic [4:0] i);
        lbcd_pkg::req_t q;
        q.cmd = c;
        q.device = d;
        q.block_number = b;
        q.buffer_index = i;
        send(q);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int hold_len;
        cycles = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        // Directed: tag extremes, hit and miss, every command, every error status.
        send_cmd(lbcd_pkg::OP_GET, 8'h00, 32'h0, 5'd0);
        send_cmd(lbcd_pkg::OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        send_cmd(lbcd_pkg::OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
        send_cmd(lbcd_pkg::OP_MARK_VALID, 8'h0, 32'h0, 5'd31);
        send_cmd(lbcd_pkg::OP_GET, 8'h00, 32'h0, 5'd0);
        send_cmd(lbcd_pkg::OP_RELEASE, 8'h0, 32'h0, 5'd30);
        send_cmd(lbcd_pkg::OP_RELEASE, 8'h0, 32'h0, 5'd30);
        send_cmd(lbcd_pkg::OP_UNPIN, 8'h0, 32'h0, 5'd0);
        send_cmd(lbcd_pkg::OP_PIN, 8'h0, 32'h0, 5'd0);
        send_cmd(lbcd_pkg::OP_UNPIN, 8'h0, 32'h0, 5'd0);
        send_cmd(3'd5, 8'hA5, 32'h5A5A_A5A5, 5'd31);
        send_cmd(3'd7, 8'h5A, 32'hA5A5_5A5A, 5'd0);
        // Drive entry 31 to the count ceiling, then overflow it by pin.
        for (int k = 0; k < 256; k++)
            send_cmd(lbcd_pkg::OP_PIN, 8'h0, 32'h0, 5'd31);
        send_cmd(lbcd_pkg::OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
        // Exhaust every free entry so a miss finds nothing.
        for (int k = 0; k < 33; k++)
            send_cmd(lbcd_pkg::OP_GET, 8'h7E, 32'(k + 1000), 5'd0);
        for (int k = 0; k < lbcd_pkg::BUFFER_COUNT; k++)
            for (int j = 0; j < 3; j++)
                send_cmd(lbcd_pkg::OP_RELEASE, 8'h0, 32'h0, 5'(k));
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            sender_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 77 : 0;
            receiver_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 21 : 0;
            for (int n = 0; n < 400; n++)
            begin
                if (ph == 2 && n == 100)
                begin
                    receiver_hold = 1'b1;
                    fork
                    begin
                        hold_len = 0;
                        while (hold_len < 300)
                        begin
                            @(posedge clk);
                            hold_len++;
                        end
                        receiver_hold = 1'b0;
                    end
                    join_none
                end
                send(make_word());
            end
            drain();
        end

        repeat (80) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
